[rtl/nfid_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfid_pkg
// Shared types and constants of the next-fit identifier allocator.
// ----------------------------------------------------------------------------
package nfid_pkg;

	localparam int unsigned ID_COUNT_DEF = 4096;
	localparam int unsigned FIRST_ID_DEF = 301;
	localparam int unsigned WORD_W       = 64;
	localparam int unsigned GRANT_W      = 13;

	typedef enum logic {
		ACT_ALLOC   = 1'b0,
		ACT_RELEASE = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		STAT_GRANTED  = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_RELEASED = 2'd2,
		STAT_BAD_ID   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_REL,
		ST_SCAN
	} state_t;

	typedef struct packed {
		action_t              action;
		logic [GRANT_W-1:0]   release_id;
	} cmd_t;

	typedef struct packed {
		logic [GRANT_W-1:0]   granted_id;
		status_t              status;
	} result_t;

endpackage

[rtl/next_fit_id_allocator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_fit_id_allocator_top
// Next-fit identifier allocator over a bitmap kept in a word-wide memory.
// Bad-id release: answered from idle. Release: reads its map word, clears the
// bit in ST_REL. Allocate: scans one map word per cycle from the entry after
// the last grant to a free bit or a full wrap. Throughput: one command at a
// time; busy high until its result beat, never for a bad id. Reset: a clearing
// pass writes the map one word a cycle, busy high. Results cannot be stalled.
// ----------------------------------------------------------------------------
module next_fit_id_allocator_top
	import nfid_pkg::*;
#(
	parameter int unsigned ID_COUNT = ID_COUNT_DEF,
	parameter int unsigned FIRST_ID = FIRST_ID_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  cmd_t    cmd,
	output logic    done,
	output result_t result
);

	localparam int unsigned WORDS = (ID_COUNT + WORD_W - 1) / WORD_W;
	localparam int unsigned WA    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int unsigned BW    = $clog2(WORD_W);
	localparam int unsigned EIW   = WA + BW;
	localparam int unsigned CW    = $clog2(WORDS + 1);
	localparam int unsigned TAIL  = ID_COUNT - (WORDS - 1) * WORD_W;

	logic [WORD_W-1:0] mem [WORDS];

	state_t            state_q, state_d;
	logic [WA-1:0]     clr_q;
	logic [EIW-1:0]    last_q;
	logic [WA-1:0]     cur_q;
	logic [CW-1:0]     cnt_q;
	logic [BW-1:0]     bs_q;
	logic [BW-1:0]     rbit_q;
	logic [WORD_W-1:0] rdata_q;
	logic              done_q;
	result_t           res_q;

	logic              accept;
	logic [EIW-1:0]    start_idx;
	logic [31:0]       rel_full;
	logic [EIW-1:0]    rel_idx;
	logic              in_rng;
	logic [WORD_W-1:0] masked;
	logic              free_any;
	logic [BW-1:0]     free_bit;
	logic [31:0]       gid_full;
	logic              last_word;
	logic              final_pass;

	logic              rd_en;
	logic [WA-1:0]     raddr;
	logic              we;
	logic [WA-1:0]     waddr;
	logic [WORD_W-1:0] wdata;
	logic              done_d;
	result_t           res_d;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && (state_q == ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

	assign start_idx  = (last_q == EIW'(ID_COUNT - 1)) ? '0 : last_q + EIW'(1);
	assign rel_full   = 32'(cmd.release_id) - 32'(FIRST_ID);
	assign rel_idx    = rel_full[EIW-1:0];
	assign in_rng     = (32'(cmd.release_id) >= 32'(FIRST_ID))
		&& (32'(cmd.release_id) < 32'(FIRST_ID) + 32'(ID_COUNT));
	assign last_word  = (cur_q == WA'(WORDS - 1));
	assign final_pass = (cnt_q == CW'(WORDS));
	assign gid_full   = 32'(FIRST_ID) + 32'({cur_q, free_bit});

	always_comb begin
		for (int i = 0; i < int'(WORD_W); i++) begin
			masked[i] = rdata_q[i]
				|| (last_word && (i >= int'(TAIL)))
				|| ((cnt_q == '0) && (BW'(i) < bs_q))
				|| (final_pass && (BW'(i) >= bs_q));
		end
	end

	always_comb begin
		free_any = 1'b0;
		free_bit = '0;
		for (int i = int'(WORD_W) - 1; i >= 0; i--) begin
			if (!masked[i]) begin
				free_any = 1'b1;
				free_bit = BW'(i);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == WA'(WORDS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (cmd.action == ACT_ALLOC) state_d = ST_SCAN;
					else if (in_rng) state_d = ST_REL;
				end
			end
			ST_REL: begin
				state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (free_any || final_pass) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		rd_en  = 1'b0;
		raddr  = cur_q;
		we     = 1'b0;
		waddr  = cur_q;
		wdata  = rdata_q;
		done_d = 1'b0;
		res_d  = '{granted_id: '0, status: STAT_GRANTED};
		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			ST_IDLE: begin
				if (accept) begin
					if (cmd.action == ACT_ALLOC) begin
						rd_en = 1'b1;
						raddr = start_idx[EIW-1:BW];
					end else if (in_rng) begin
						rd_en = 1'b1;
						raddr = rel_idx[EIW-1:BW];
					end else begin
						done_d       = 1'b1;
						res_d.status = STAT_BAD_ID;
					end
				end
			end
			ST_REL: begin
				we           = 1'b1;
				wdata        = rdata_q & ~(WORD_W'(1) << rbit_q);
				done_d       = 1'b1;
				res_d.status = STAT_RELEASED;
			end
			ST_SCAN: begin
				if (free_any) begin
					we               = 1'b1;
					wdata            = rdata_q | (WORD_W'(1) << free_bit);
					done_d           = 1'b1;
					res_d.granted_id = gid_full[GRANT_W-1:0];
					res_d.status     = STAT_GRANTED;
				end else if (final_pass) begin
					done_d       = 1'b1;
					res_d.status = STAT_FULL;
				end else begin
					rd_en = 1'b1;
					raddr = last_word ? '0 : cur_q + WA'(1);
				end
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// bitmap memory
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (rd_en) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			last_q  <= EIW'(ID_COUNT - 1);
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + WA'(1);
			if (state_q == ST_SCAN && free_any) last_q <= {cur_q, free_bit};
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (rd_en) cur_q <= raddr;
		if (accept) begin
			bs_q   <= start_idx[BW-1:0];
			rbit_q <= rel_idx[BW-1:0];
			cnt_q  <= '0;
		end else if (state_q == ST_SCAN) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while a command is still in flight");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted command neither started nor answered");

	a_zero_id: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != STAT_GRANTED) |-> (result.granted_id == '0))
		else $error("nonzero id on a result that is not a grant");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (cnt_q <= CW'(WORDS)))
		else $error("scan ran past a full wrap of the map");

endmodule
